>>> rtl/spht_pkg.sv
`default_nettype none
package spht_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned UsedW        = $clog2(TableEntries + 1);
  localparam int unsigned ValW         = 48;
  localparam int unsigned TagW         = 15;
  localparam int unsigned CntW         = 16;
  localparam int unsigned WordW        = 64;
  localparam int unsigned SlotW        = 4;
  localparam int unsigned OutW         = 152;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QPtrW        = $clog2(QueueDepth);
  localparam int unsigned QCntW        = $clog2(QueueDepth + 1);

  // configuration register indexes
  localparam logic [1:0] REG_HEAP_ID_TAG   = 2'd0;
  localparam logic [1:0] REG_HEAP_SIZE_TAG = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_TAG   = 2'd2;

  typedef struct packed {
    logic [TagW-1:0] id_tag;
    logic [TagW-1:0] size_tag;
    logic [TagW-1:0] payload_tag;
  } tags_t;

  // one finished packet header, handed from front to back
  typedef struct packed {
    logic [ValW-1:0] ident;
    logic [ValW-1:0] size;
    logic [ValW-1:0] payload;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/spead_heap_progress_tracker_unit.sv
`default_nettype none
// Tracks progress of SPEAD heaps from packet header words. The input stream takes one
// 64-bit header word per item (tuser marks a packet's first word, whose low 16 bits give
// the item count); the front end accepts a word every cycle while its two-entry job queue
// has room. When a packet's last item word arrives, its latched heap id, heap size and
// payload length go to the back end. Its lookup state does a parallel compare of the id
// against the live entries of the 16-entry table, and its update state then does the
// read-modify-write of the matching or newly inserted entry. It takes no new packet until
// the last is through, and a result waits in an output register without stalling the
// lookup of the next one. Tag registers are written over APB at 0x0, 0x4 and 0x8.
module spead_heap_progress_tracker_unit
  import spht_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [WordW-1:0]    s_axis_tdata,  // header_word
  input  wire logic                s_axis_tuser,  // first_word
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // heap_ident, heap_total, bytes_left, slot, new_heap, table_full, underflow, 1 pad
  output logic [OutW-1:0]          m_axis_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  tags_t      tags_q, tags_d;
  logic [1:0] reg_idx;
  logic       cfg_wr;
  job_t       push_job;
  job_t       head_job;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    tags_d = tags_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_HEAP_ID_TAG:   tags_d.id_tag      = pwdata[TagW-1:0];
        REG_HEAP_SIZE_TAG: tags_d.size_tag    = pwdata[TagW-1:0];
        REG_PAYLOAD_TAG:   tags_d.payload_tag = pwdata[TagW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEAP_ID_TAG:   prdata = 32'(tags_q.id_tag);
      REG_HEAP_SIZE_TAG: prdata = 32'(tags_q.size_tag);
      REG_PAYLOAD_TAG:   prdata = 32'(tags_q.payload_tag);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tags_q.id_tag      <= TagW'(1);
      tags_q.size_tag    <= TagW'(2);
      tags_q.payload_tag <= TagW'(4);
    end else begin
      tags_q <= tags_d;
    end
  end

  spht_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_word_i    (s_axis_tdata),
    .in_first_i   (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .tags_i       (tags_q),
    .queue_full_i (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  spht_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  spht_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/spht_queue.sv
`default_nettype none
module spht_queue
  import spht_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  job_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/spht_front.sv
`default_nettype none
module spht_front
  import spht_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [WordW-1:0] in_word_i,
  input  wire logic             in_first_i,
  output logic                  in_ready_o,
  input  wire tags_t            tags_i,
  input  wire logic             queue_full_i,
  output logic                  push_o,
  output job_t                  job_o
);

  logic [CntW-1:0] items_q, items_d;
  logic            in_header_q, in_header_d;
  logic [ValW-1:0] ident_q, ident_d;
  logic [ValW-1:0] size_q, size_d;
  logic [ValW-1:0] payload_q, payload_d;
  logic            accept;
  logic [TagW-1:0] tag;
  logic [ValW-1:0] val;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tag        = in_word_i[WordW-2 -: TagW];
  assign val        = in_word_i[ValW-1:0];

  always_comb begin
    items_d     = items_q;
    in_header_d = in_header_q;
    ident_d     = ident_q;
    size_d      = size_q;
    payload_d   = payload_q;
    push_o      = 1'b0;
    if (accept) begin
      if (in_first_i) begin
        items_d   = in_word_i[CntW-1:0];
        ident_d   = '0;
        size_d    = '0;
        payload_d = '0;
        if (in_word_i[CntW-1:0] == '0) begin
          // empty header ends at once
          in_header_d = 1'b0;
          push_o      = 1'b1;
        end else begin
          in_header_d = 1'b1;
        end
      end else if (in_header_q) begin
        if (tag == tags_i.id_tag)      ident_d   = val;
        if (tag == tags_i.size_tag)    size_d    = val;
        if (tag == tags_i.payload_tag) payload_d = val;
        items_d = items_q - 1'b1;
        if (items_q == CntW'(1)) begin
          in_header_d = 1'b0;
          push_o      = 1'b1;
        end
      end
    end
  end

  assign job_o.ident   = ident_d;
  assign job_o.size    = size_d;
  assign job_o.payload = payload_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_q     <= '0;
      in_header_q <= 1'b0;
      ident_q     <= '0;
      size_q      <= '0;
      payload_q   <= '0;
    end else begin
      items_q     <= items_d;
      in_header_q <= in_header_d;
      ident_q     <= ident_d;
      size_q      <= size_d;
      payload_q   <= payload_d;
    end
  end

`ifndef ASSERT_OFF
  a_open_has_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_header_q |-> items_q != '0)
    else $error("open header with zero items left");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_full_i |-> !push_o)
    else $error("job pushed into full queue");

  a_push_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !in_header_q)
    else $error("header still open after packet end");
`endif

endmodule
`default_nettype wire

>>> rtl/spht_back.sv
`default_nettype none
module spht_back
  import spht_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire job_t            head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [OutW-1:0]      out_data_o
);

  localparam logic ST_LOOK = 1'b0;
  localparam logic ST_UPDT = 1'b1;

  logic             state_q, state_d;
  logic [ValW-1:0]  ident_tbl_q [TableEntries];
  logic [ValW-1:0]  size_tbl_q  [TableEntries];
  logic [ValW-1:0]  left_tbl_q  [TableEntries];
  logic [UsedW-1:0] used_q, used_d;
  job_t             job_q;
  logic             found_q, found_d;
  logic [IdxW-1:0]  hit_q, hit_d;
  logic             out_valid_q, out_valid_d;
  logic [OutW-1:0]  out_data_q, out_data_d;

  logic             can_emit;
  logic             is_full;
  logic [IdxW-1:0]  idx;
  logic [ValW-1:0]  base;
  logic             under;
  logic [ValW-1:0]  left;
  logic [ValW-1:0]  total;
  logic             wr_en;

  assign can_emit = !out_valid_q || out_ready_i;
  assign is_full  = !found_q && (used_q >= UsedW'(TableEntries));
  assign idx      = found_q ? hit_q : used_q[IdxW-1:0];
  assign base     = found_q ? left_tbl_q[hit_q] : job_q.size;
  assign total    = found_q ? size_tbl_q[hit_q] : job_q.size;
  assign under    = job_q.payload > base;
  assign left     = under ? '0 : base - job_q.payload;
  assign wr_en    = (state_q == ST_UPDT) && can_emit && !is_full;

  // lookup over all live entries, lowest match wins
  always_comb begin
    found_d = 1'b0;
    hit_d   = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if ((UsedW'(i) < used_q) && (ident_tbl_q[i] == head_i.ident)) begin
        found_d = 1'b1;
        hit_d   = IdxW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_LOOK: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_UPDT;
        end
      end
      ST_UPDT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          state_d     = ST_LOOK;
          if (is_full) begin
            out_data_d = {1'b0, 1'b0, 1'b1, 1'b0, SlotW'(0), ValW'(0), ValW'(0), job_q.ident};
          end else begin
            out_data_d = {1'b0, under, 1'b0, !found_q, SlotW'(idx), left, total, job_q.ident};
            if (!found_q) used_d = used_q + 1'b1;
          end
        end
      end
      default: state_d = ST_LOOK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOOK;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q   <= head_i;
      found_q <= found_d;
      hit_q   <= hit_d;
    end
    out_data_q <= out_data_d;
    if (wr_en) begin
      if (!found_q) begin
        ident_tbl_q[idx] <= job_q.ident;
        size_tbl_q[idx]  <= job_q.size;
      end
      left_tbl_q[idx] <= left;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(TableEntries))
    else $error("entry count beyond table size");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !found_q) |=> used_q == $past(used_q) + 1'b1)
    else $error("insert did not bump entry count");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[148] && out_data_q[149]))
    else $error("new heap and full table both set");

  a_pop_only_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_LOOK) && !empty_i)
    else $error("pop outside lookup or from empty queue");
`endif

endmodule
`default_nettype wire

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spht_pkg::*;

  localparam logic [ValW-1:0] AllOnes = '1;
  localparam int unsigned PhaseWords = 340;

  typedef struct packed {
    logic [ValW-1:0]  ident;
    logic [ValW-1:0]  total;
    logic [ValW-1:0]  left;
    logic [SlotW-1:0] slot;
    logic             new_heap;
    logic             full;
    logic             under;
  } heap_result_t;

  class heap_progress_scoreboard;
    logic [TagW-1:0] tags [3] = '{15'd1, 15'd2, 15'd4};
    logic [CntW-1:0] count_left = '0;
    bit              hdr_open = 1'b0;
    logic [ValW-1:0] cur_ident = '0;
    logic [ValW-1:0] cur_size = '0;
    logic [ValW-1:0] cur_pay = '0;
    int unsigned     used = 0;
    logic [ValW-1:0] idents [TableEntries];
    logic [ValW-1:0] totals [TableEntries];
    logic [ValW-1:0] lefts [TableEntries];
    heap_result_t    heap_updates_due [$];
    int unsigned     errors = 0;

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    // table lookup and update once a packet header is complete
    function heap_result_t close_packet();
      heap_result_t r;
      int hit;
      r = '0;
      r.ident = cur_ident;
      hit = -1;
      for (int i = 0; i < used; i++) begin
        if (hit < 0 && idents[i] == cur_ident) hit = i;
      end
      if (hit < 0) begin
        if (used >= TableEntries) begin
          r.full = 1'b1;
          return r;
        end
        hit = used;
        idents[hit] = cur_ident;
        totals[hit] = cur_size;
        lefts[hit] = cur_size;
        used++;
        r.new_heap = 1'b1;
      end
      if (cur_pay > lefts[hit]) begin
        lefts[hit] = '0;
        r.under = 1'b1;
      end else begin
        lefts[hit] -= cur_pay;
      end
      r.total = totals[hit];
      r.left = lefts[hit];
      r.slot = SlotW'(hit);
      return r;
    endfunction

    function void take_word(input logic [WordW-1:0] w, input logic first);
      logic [TagW-1:0] tag;
      logic [ValW-1:0] val;
      if (first) begin
        count_left = w[CntW-1:0];
        cur_ident = '0;
        cur_size = '0;
        cur_pay = '0;
        hdr_open = (count_left != 0);
        if (count_left == 0) heap_updates_due.push_back(close_packet());
        return;
      end
      if (!hdr_open || count_left == 0) return;
      tag = w[62:48];
      val = w[ValW-1:0];
      // one word may feed several latches when tags coincide
      if (tag == tags[REG_HEAP_ID_TAG]) cur_ident = val;
      if (tag == tags[REG_HEAP_SIZE_TAG]) cur_size = val;
      if (tag == tags[REG_PAYLOAD_TAG]) cur_pay = val;
      count_left--;
      if (count_left == 0) begin
        hdr_open = 1'b0;
        heap_updates_due.push_back(close_packet());
      end
    endfunction

    task check_result(input logic [OutW-1:0] d);
      heap_result_t got;
      heap_result_t want;
      got.ident = d[47:0];
      got.total = d[95:48];
      got.left = d[143:96];
      got.slot = d[147:144];
      got.new_heap = d[148];
      got.full = d[149];
      got.under = d[150];
      if (heap_updates_due.size() == 0) begin
        report($sformatf("result with none pending, heap_ident %h", got.ident));
        return;
      end
      want = heap_updates_due.pop_front();
      if (got.ident !== want.ident)
        report($sformatf("heap_ident %h, expected %h", got.ident, want.ident));
      if (got.total !== want.total)
        report($sformatf("heap_total %h, expected %h", got.total, want.total));
      if (got.left !== want.left)
        report($sformatf("bytes_left %h, expected %h", got.left, want.left));
      if (got.slot !== want.slot)
        report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
      if (got.new_heap !== want.new_heap)
        report($sformatf("new_heap %b, expected %b", got.new_heap, want.new_heap));
      if (got.full !== want.full)
        report($sformatf("table_full %b, expected %b", got.full, want.full));
      if (got.under !== want.under)
        report($sformatf("underflow %b, expected %b", got.under, want.under));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [WordW-1:0]  s_axis_tdata;   // header_word
  logic              s_axis_tuser;   // first_word
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // heap_ident, heap_total, bytes_left, slot, new_heap, table_full, underflow, pad
  logic [OutW-1:0]   m_axis_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  logic              hold_req;
  logic              calm;
  int unsigned       words_sent;
  logic [ValW-1:0]   id_pool [20];

  heap_progress_scoreboard sb;

  spead_heap_progress_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ValW-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ValW-1:0];
  endfunction

  task automatic send_word(input logic [WordW-1:0] w, input logic first);
    if (!calm && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tuser <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_word(w, first);
  endtask

  function automatic logic [WordW-1:0] item(input logic imm, input logic [TagW-1:0] tag,
                                            input logic [ValW-1:0] val);
    return {imm, tag, val};
  endfunction

  // one packet, a stray word, a cut-off header or an empty header
  task automatic send_packet(input bit whole);
    int unsigned     roll;
    int unsigned     k;
    int unsigned     n;
    logic [TagW-1:0] tag;
    logic [ValW-1:0] val;
    roll = whole ? $urandom_range(16, 99) : $urandom_range(0, 99);
    if (roll < 8) begin
      send_word(item(1'($urandom), 15'($urandom), rand48()), 1'b0);
      return;
    end
    if (roll < 13) begin
      k = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 8) : $urandom_range(2, 65535);
      n = $urandom_range(0, (k - 1 < 7) ? k - 1 : 7);
    end else if (roll < 16) begin
      k = 0;
      n = 0;
    end else begin
      k = $urandom_range(1, 7);
      n = k;
    end
    send_word({rand48(), CntW'(k)}, 1'b1);
    words_sent++;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          tag = sb.tags[REG_HEAP_ID_TAG];
          val = ($urandom_range(0, 99) < 90) ? id_pool[$urandom_range(0, 13)]
                                              : id_pool[$urandom_range(14, 19)];
        end
        3, 4: begin
          tag = sb.tags[REG_HEAP_SIZE_TAG];
          case ($urandom_range(0, 9))
            0:             val = AllOnes;
            1, 2, 3, 4, 5: val = ValW'($urandom_range(0, 1 << 20));
            default:       val = rand48();
          endcase
        end
        5, 6, 7: begin
          tag = sb.tags[REG_PAYLOAD_TAG];
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: val = ValW'($urandom_range(0, 4095));
            6, 7:             val = ValW'($urandom_range(0, 1 << 20));
            8:                val = rand48();
            default:          val = ($urandom_range(0, 1) != 0) ? AllOnes : '0;
          endcase
        end
        default: begin
          tag = 15'($urandom);
          val = rand48();
        end
      endcase
      send_word(item(1'($urandom), tag, val), 1'b0);
      words_sent++;
    end
  endtask

  task automatic wait_idle(input int unsigned settle);
    while (sb.heap_updates_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [TagW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {17'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.tags[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [1:0] idx);
    logic [31:0] want;
    want = {17'd0, sb.tags[idx]};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      sb.report($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_tags();
    apb_read_check(REG_HEAP_ID_TAG);
    apb_read_check(REG_HEAP_SIZE_TAG);
    apb_read_check(REG_PAYLOAD_TAG);
  endtask

  task automatic apply_tags(input logic [TagW-1:0] id_tag, input logic [TagW-1:0] size_tag,
                            input logic [TagW-1:0] pay_tag);
    apb_write(REG_HEAP_ID_TAG, id_tag);
    apb_write(REG_HEAP_SIZE_TAG, size_tag);
    apb_write(REG_PAYLOAD_TAG, pay_tag);
    check_tags();
  endtask

  // short directed run with the reset tags: id 1, size 2, payload 4
  task automatic directed_packets();
    send_word({AllOnes, 16'h0000}, 1'b1);               // empty header, heap id 0
    send_word(item(1'b1, 15'd4, 48'h1234), 1'b0);       // stray word, ignored
    send_word({rand48(), 16'd3}, 1'b1);
    send_word(item(1'b0, 15'd1, AllOnes), 1'b0);
    send_word(item(1'b1, 15'd2, AllOnes), 1'b0);
    send_word(item(1'b0, 15'd4, 48'h0), 1'b0);
    send_word({rand48(), 16'd2}, 1'b1);                 // payload equals remaining
    send_word(item(1'b1, 15'd1, AllOnes), 1'b0);
    send_word(item(1'b0, 15'd4, AllOnes), 1'b0);
    send_word({rand48(), 16'd2}, 1'b1);                 // payload past remaining
    send_word(item(1'b0, 15'd1, AllOnes), 1'b0);
    send_word(item(1'b1, 15'd4, 48'h1), 1'b0);
    send_word(item(1'b0, 15'd1, 48'h5), 1'b0);          // beyond item count
    send_word({rand48(), 16'hffff}, 1'b1);              // cut off by next header
    send_word(item(1'b0, 15'd1, 48'h777), 1'b0);
    send_word({rand48(), 16'd1}, 1'b1);
    send_word(item(1'b0, 15'd2, 48'h100), 1'b0);
    send_word({rand48(), 16'd5}, 1'b1);                 // repeated id item, last one counts
    send_word(item(1'b0, 15'd1, 48'ha), 1'b0);
    send_word(item(1'b1, 15'h7fff, AllOnes), 1'b0);
    send_word(item(1'b0, 15'd1, 48'hb), 1'b0);
    send_word(item(1'b0, 15'd2, 48'h1000), 1'b0);
    send_word(item(1'b1, 15'd4, 48'h10), 1'b0);
  endtask

  initial begin : sink
    int unsigned hold_left;
    bit          hold_started;
    hold_left = 0;
    hold_started = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  initial begin : stimulus
    int unsigned goal;
    sb = new();
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    hold_req <= 1'b0;
    calm <= 1'b0;
    words_sent = 0;
    id_pool[0] = '0;
    id_pool[1] = AllOnes;
    for (int i = 2; i < 20; i++) id_pool[i] = rand48();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_tags();
    directed_packets();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: apply_tags(15'h7fff, 15'h0000, 15'h2aaa);
        2: apply_tags(15'd5, 15'd5, 15'd5);
        3: apply_tags(15'($urandom), 15'($urandom), 15'($urandom));
        4: apply_tags(15'h0000, 15'h7fff, 15'h5555);
        default: ;
      endcase
      calm <= (phase == 2);
      goal = words_sent + PhaseWords;
      while (words_sent < goal) begin
        // long output stall midway through the second phase
        if (phase == 1 && words_sent + PhaseWords / 2 >= goal) hold_req <= 1'b1;
        send_packet(1'b0);
      end
      send_packet(1'b1);
      s_axis_tvalid <= 1'b0;
      wait_idle(8);
    end
    wait_idle(20);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/spht_pkg.sv
rtl/spht_queue.sv
rtl/spht_front.sv
rtl/spht_back.sv
rtl/spead_heap_progress_tracker_unit.sv
sim/tb.sv
